>>> rtl/oist_pkg.sv
// ----------------------------------------------------------------------------
// oist_pkg: shared types and constants for the ordered integer set table
// Command and result payloads, operation and status codes.
// ----------------------------------------------------------------------------
package oist_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int VALUE_W          = 32;
    localparam int INDEX_W          = 4;
    localparam int COUNT_W          = 5;

    typedef enum logic [1:0] {
        FN_ADD      = 2'd0,
        FN_REMOVE   = 2'd1,
        FN_CONTAINS = 2'd2,
        FN_READ     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_func                      func;
        logic signed [VALUE_W-1:0]  value;
        logic [INDEX_W-1:0]         index;
    } t_set_cmd;

    typedef struct packed {
        logic                       hit;
        logic [COUNT_W-1:0]         count;
        logic signed [VALUE_W-1:0]  entry_value;
        t_status                    status;
    } t_set_result;

endpackage

>>> rtl/oist_ram.sv
// ----------------------------------------------------------------------------
// oist_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module oist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> rtl/ordered_integer_set_table.sv
// ----------------------------------------------------------------------------
// ordered_integer_set_table: set of distinct 32-bit integers, insertion order
// Add, remove, membership test and indexed read over an entry RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_cmd and raise start while busy is low; that edge takes the
//   transfer. busy stays high until the result is produced (a read out of
//   range answers from idle and never raises busy), and o_done pulses for
//   exactly one cycle with o_result valid. The receiver cannot stall:
//   sample o_result whenever o_done is high.
// One item at a time; the search reads one entry per cycle through the
// single RAM read port, and on a remove hit the shift then moves one entry
// per cycle to close the gap.
// Reset clears the control state and the entry count, not the RAM; entries
// beyond the count are never read, so the RAM needs no clearing pass. A new
// command is taken in the cycle the previous result strobes.
// ----------------------------------------------------------------------------
module ordered_integer_set_table
    import oist_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_set_cmd    i_cmd,
    output logic        busy,
    output logic        o_done,
    output t_set_result o_result
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEARCH,
        S_SHIFT
    } t_state;

    t_state      r_state, n_state;
    t_set_cmd    r_cmd, n_cmd;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_i, n_i;      // next RAM address to issue
    logic [CW-1:0] r_pi, n_pi;    // address whose data returns this cycle
    logic          r_pv, n_pv;    // read data this cycle is live
    logic          r_done, n_done;
    t_set_result   r_result, n_result;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [VALUE_W-1:0] ram_wdata, ram_rdata;

    logic [CMPW-1:0] idx_ext, count_ext;
    logic            match;

    oist_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign idx_ext   = CMPW'(i_cmd.index);
    assign count_ext = CMPW'(r_count);
    assign match     = r_pv && (ram_rdata == r_cmd.value);

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_count  = r_count;
        n_i      = r_i;
        n_pi     = r_pi;
        n_pv     = r_pv;
        n_done   = 1'b0;
        n_result = r_result;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_cmd.value;
        ram_re    = 1'b0;
        ram_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd;
                    n_i   = '0;
                    n_pv  = 1'b0;
                    if (i_cmd.func == FN_READ) begin
                        if (idx_ext < count_ext) begin
                            // fetch the entry, answer when the data lands
                            ram_re    = 1'b1;
                            ram_raddr = idx_ext[AW-1:0];
                            n_state   = S_READ;
                        end else begin
                            n_done               = 1'b1;
                            n_result.hit         = 1'b0;
                            n_result.count       = COUNT_W'(r_count);
                            n_result.entry_value = '0;
                            n_result.status      = ST_RANGE;
                        end
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end

            S_READ: begin
                n_done               = 1'b1;
                n_result.hit         = 1'b1;
                n_result.count       = COUNT_W'(r_count);
                n_result.entry_value = ram_rdata;
                n_result.status      = ST_OK;
                n_state              = S_IDLE;
            end

            S_SEARCH: begin
                n_result.entry_value = '0;
                n_result.status      = ST_OK;
                if (match) begin
                    n_result.hit = 1'b1;
                    if (r_cmd.func == FN_REMOVE) begin
                        // close the gap: pull each later entry down one place
                        n_i     = r_pi + CW'(1);
                        n_pv    = 1'b0;
                        n_state = S_SHIFT;
                    end else begin
                        n_done         = 1'b1;
                        n_result.count = COUNT_W'(r_count);
                        n_state        = S_IDLE;
                    end
                end else if (!r_pv && (r_i >= r_count)) begin
                    // value absent
                    n_done         = 1'b1;
                    n_result.hit   = 1'b0;
                    n_result.count = COUNT_W'(r_count);
                    n_state        = S_IDLE;
                    if (r_cmd.func == FN_ADD) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_result.status = ST_FULL;
                        end else begin
                            ram_we         = 1'b1;
                            ram_waddr      = r_count[AW-1:0];
                            n_count        = r_count + CW'(1);
                            n_result.count = COUNT_W'(r_count + CW'(1));
                        end
                    end
                end else if (r_i < r_count) begin
                    // advance the scan one entry
                    ram_re    = 1'b1;
                    ram_raddr = r_i[AW-1:0];
                    n_pv      = 1'b1;
                    n_pi      = r_i;
                    n_i       = r_i + CW'(1);
                end else begin
                    n_pv = 1'b0;
                end
            end

            S_SHIFT: begin
                if (r_pv) begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(r_pi - CW'(1));
                    ram_wdata = ram_rdata;
                end
                if (r_i < r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_i[AW-1:0];
                    n_pv      = 1'b1;
                    n_pi      = r_i;
                    n_i       = r_i + CW'(1);
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_count              = r_count - CW'(1);
                        n_done               = 1'b1;
                        n_result.hit         = 1'b1;
                        n_result.count       = COUNT_W'(r_count - CW'(1));
                        n_result.entry_value = '0;
                        n_result.status      = ST_OK;
                        n_state              = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pv    <= n_pv;
            r_done  <= n_done;
        end
        // payload and scan indexes: no reset needed
        r_cmd    <= n_cmd;
        r_i      <= n_i;
        r_pi     <= n_pi;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> dv/tb_ordered_integer_set_table.sv
// ----------------------------------------------------------------------------
// tb_ordered_integer_set_table: self-checking bench for the ordered set table
// Drives add, remove, contains and read commands through the start/busy
// handshake, mirrors the set in a shadow table to predict every result, and
// compares each strobed result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_ordered_integer_set_table;
    import oist_pkg::*;

    localparam int SET_CAP      = DEFAULT_CAPACITY;
    localparam int POOL_SIZE    = 20;          // a few more values than slots
    localparam int RAND_BATCHES = 10;
    localparam int BATCH_ITEMS  = 65;
    localparam int DRAIN_CYCLES = 2 * SET_CAP + 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 20;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        start    = 1'b0;
    t_set_cmd    cmd_in   = '0;
    logic        busy;
    logic        o_done;
    t_set_result o_result;

    // Shadow copy of the set, updated once per accepted transfer.
    logic [VALUE_W-1:0] shadow_entries [SET_CAP];
    int                 shadow_count;

    // Predicted results still waiting for their strobe, oldest first.
    t_set_result        pending_results [$];

    // Values that random traffic draws from, so adds and removes collide.
    logic [VALUE_W-1:0] value_pool [POOL_SIZE];

    int errors        = 0;
    int results_seen  = 0;
    int cycle_count   = 0;
    int full_refusals = 0;
    int range_reads   = 0;
    int times_emptied = 0;
    int op_tally [4]  = '{0, 0, 0, 0};

    ordered_integer_set_table #(
        .CAPACITY (SET_CAP)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (cmd_in),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run: no correct run comes anywhere near this many cycles.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still pending",
                     $time, cycle_count, pending_results.size());
            $display("ordered_integer_set_table test failed");
            $finish;
        end
    end

    // Work out the result of one command and advance the shadow set.
    // Search for the first match, then append on add or close the gap on remove.
    function automatic t_set_result apply_set_op(input t_set_cmd cmd);
        t_set_result r;
        int          pos;
        r        = '0;
        r.status = ST_OK;
        if (cmd.func == FN_READ) begin
            if (int'(cmd.index) < shadow_count) begin
                r.hit         = 1'b1;
                r.entry_value = shadow_entries[cmd.index];
            end else begin
                r.status = ST_RANGE;
            end
        end else begin
            pos = shadow_count;
            for (int i = shadow_count - 1; i >= 0; i--) begin
                if (shadow_entries[i] == cmd.value)
                    pos = i;
            end
            r.hit = (pos < shadow_count);
            if (cmd.func == FN_ADD && !r.hit) begin
                if (shadow_count >= SET_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_entries[shadow_count] = cmd.value;
                    shadow_count++;
                end
            end else if (cmd.func == FN_REMOVE && r.hit) begin
                for (int i = pos; i + 1 < shadow_count; i++)
                    shadow_entries[i] = shadow_entries[i + 1];
                shadow_count--;
            end
        end
        r.count = shadow_count[COUNT_W-1:0];
        return r;
    endfunction

    // Present one command and hold it until the block takes the transfer.
    // start is left high, so a back-to-back command is taken without start dropping in between.
    task automatic issue_cmd(input t_func fn, input logic [VALUE_W-1:0] val,
                             input logic [INDEX_W-1:0] idx);
        t_set_cmd    cmd;
        t_set_result predicted;
        cmd.func  = fn;
        cmd.value = val;
        cmd.index = idx;
        start  <= 1'b1;
        cmd_in <= cmd;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        predicted = apply_set_op(cmd);
        pending_results.push_back(predicted);
        op_tally[fn]++;
        if (predicted.status == ST_FULL)
            full_refusals++;
        if (predicted.status == ST_RANGE)
            range_reads++;
        if (fn == FN_REMOVE && predicted.hit && predicted.count == 0)
            times_emptied++;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int draw_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Drop start over the requested gap and scramble the idle command bus meanwhile.
    task automatic pause_sender(input int n);
        t_set_cmd junk;
        if (n > 0) begin
            junk.func  = t_func'($urandom_range(0, 3));
            junk.value = $urandom;
            junk.index = INDEX_W'($urandom_range(0, 15));
            start  <= 1'b0;
            cmd_in <= junk;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input logic [VALUE_W-1:0] exp_v,
                               input logic [VALUE_W-1:0] act_v);
        if (act_v !== exp_v) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch on result %0d: expected %h, actual %h",
                         $time, name, results_seen, exp_v, act_v);
        end
    endtask

    // Results cannot be held off, so take each one on the edge that ends its
    // strobe cycle and match it against the oldest prediction.
    always @(posedge i_clk) begin
        t_set_result exp_r;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_result);
            end else begin
                exp_r = pending_results.pop_front();
                check_field("hit", VALUE_W'(exp_r.hit), VALUE_W'(o_result.hit));
                check_field("count", VALUE_W'(exp_r.count), VALUE_W'(o_result.count));
                check_field("entry_value", exp_r.entry_value, o_result.entry_value);
                check_field("status", VALUE_W'(exp_r.status), VALUE_W'(o_result.status));
            end
            results_seen++;
        end
    end

    // Empty-set corners, extreme values, duplicates, and the lone-entry remove.
    task automatic test_basic_ops();
        issue_cmd(FN_READ, 32'h0000_0000, 4'd0);         // read on empty set
        issue_cmd(FN_READ, 32'hFFFF_FFFF, 4'd15);
        pause_sender(draw_gap());
        issue_cmd(FN_REMOVE, 32'h0000_0000, 4'd0);       // remove on empty set
        issue_cmd(FN_CONTAINS, 32'h0000_0000, 4'd0);
        issue_cmd(FN_ADD, 32'h8000_0000, 4'd0);          // most negative
        issue_cmd(FN_ADD, 32'h7FFF_FFFF, 4'd0);          // most positive
        pause_sender(draw_gap());
        issue_cmd(FN_ADD, 32'h8000_0000, 4'd0);          // already present
        issue_cmd(FN_CONTAINS, 32'h7FFF_FFFF, 4'd0);
        issue_cmd(FN_CONTAINS, 32'hFFFF_FFFF, 4'd0);     // absent
        issue_cmd(FN_REMOVE, 32'h1234_5678, 4'd0);       // absent on non-empty
        issue_cmd(FN_READ, 32'h0000_0000, 4'd1);
        issue_cmd(FN_READ, 32'h0000_0000, 4'd2);         // just past the end
        pause_sender(draw_gap());
        issue_cmd(FN_REMOVE, 32'h7FFF_FFFF, 4'd0);       // last entry
        issue_cmd(FN_REMOVE, 32'h8000_0000, 4'd0);       // only entry left
    endtask

    // Fill to capacity, refuse a new value, find a duplicate already present,
    // then remove the head so every later entry has to move down.
    task automatic test_capacity_limit();
        for (int i = 0; i < SET_CAP; i++)
            issue_cmd(FN_ADD, 32'h1 << i, 4'd0);
        issue_cmd(FN_ADD, 32'hDEAD_BEEF, 4'd0);
        issue_cmd(FN_ADD, 32'h0000_0001, 4'd0);
        issue_cmd(FN_READ, 32'h0000_0000, 4'd15);
        pause_sender(draw_gap());
        issue_cmd(FN_REMOVE, 32'h0000_0001, 4'd0);
        issue_cmd(FN_READ, 32'h0000_0000, 4'd0);
    endtask

    // Alternate growing and shrinking batches so the set swings between empty
    // and full; a couple of batches run back to back with no gaps at all.
    task automatic test_random_traffic();
        int                 roll;
        int                 add_pct;
        int                 rem_pct;
        bit                 no_gaps;
        t_func              fn;
        logic [VALUE_W-1:0] val;
        logic [INDEX_W-1:0] idx;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        value_pool[4] = 32'h0000_0001;
        for (int i = 5; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;
        for (int b = 0; b < RAND_BATCHES; b++) begin
            add_pct = (b % 2 == 0) ? 50 : 15;
            rem_pct = (b % 2 == 0) ? 15 : 50;
            no_gaps = (b == 3 || b == 6);
            for (int k = 0; k < BATCH_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < add_pct)
                    fn = FN_ADD;
                else if (roll < add_pct + rem_pct)
                    fn = FN_REMOVE;
                else if (roll < add_pct + rem_pct + 15)
                    fn = FN_CONTAINS;
                else
                    fn = FN_READ;
                // Favor values already stored or in the pool to get hits.
                roll = $urandom_range(0, 99);
                if (roll < 15 && shadow_count > 0)
                    val = shadow_entries[$urandom_range(0, shadow_count - 1)];
                else if (roll < 85)
                    val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    val = $urandom;
                if (shadow_count > 0 && $urandom_range(0, 99) < 70)
                    idx = INDEX_W'($urandom_range(0, shadow_count - 1));
                else
                    idx = INDEX_W'($urandom_range(0, 15));
                issue_cmd(fn, val, idx);
                if (!no_gaps)
                    pause_sender(draw_gap());
            end
        end
    endtask

    initial begin
        shadow_count = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_capacity_limit();
        test_random_traffic();

        // Release the bus, let every prediction come back, then give the
        // block a little longer in case a stray strobe follows.
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d adds, %0d removes, %0d membership tests, %0d reads; %0d results checked.",
                 op_tally[FN_ADD], op_tally[FN_REMOVE], op_tally[FN_CONTAINS],
                 op_tally[FN_READ], results_seen);
        $display("Set refused %0d adds when full, emptied %0d times, %0d reads past the end.",
                 full_refusals, times_emptied, range_reads);
        if (errors == 0) begin
            $display("ordered_integer_set_table test passed");
        end else begin
            $display("ordered_integer_set_table test failed");
        end
        $finish;
    end

endmodule
